@@ rtl/core/srb_pkg.sv @@
// shared types and constants for the sequence reorder buffer
// request and result structs, status codes, controller command and status groups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

   localparam int SEQ_BITS             = 32;
   localparam int PAYLOAD_BITS         = 64;
   localparam int DEFAULT_WINDOW_SLOTS = 64;

   localparam logic OP_DELIVER = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   localparam logic [2:0] ST_RELEASED    = 3'd0;
   localparam logic [2:0] ST_FLUSHED     = 3'd1;
   localparam logic [2:0] ST_HELD        = 3'd2;
   localparam logic [2:0] ST_STALE       = 3'd3;
   localparam logic [2:0] ST_TOO_FAR     = 3'd4;
   localparam logic [2:0] ST_FLUSH_EMPTY = 3'd5;

   typedef enum logic [1:0] {
      SRC_REQUEST = 2'd0,
      SRC_SLOT    = 2'd1,
      SRC_ZERO    = 2'd2
   } emit_src_type;

   typedef struct packed {
      logic                    operation;
      logic [SEQ_BITS-1:0]     seq_number;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    has_task;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [SEQ_BITS-1:0]     out_seq_number;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic                    out_has_task;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0]     seq_number;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    has_task;
   } slot_entry_type;

   typedef struct packed {
      logic         load_req;
      logic         write_slot;
      logic         read_slot;
      logic         read_from_scan;
      logic         release_head;
      logic         release_scan;
      logic         scan_init;
      logic         scan_step;
      logic         flush_done;
      logic         emit;
      emit_src_type emit_src;
      logic [2:0]   emit_status;
      logic         emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic is_stale;
      logic is_too_far;
      logic diff_zero;
      logic count_zero;
      logic count_one;
      logic head_next_valid;
      logic scan_valid;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/srb_datapath.sv @@
// datapath of the sequence reorder buffer: slot memory, valid bits, pointers
// and the result register; driven by srb_controller, uses srb_pkg
`timescale 1ns / 1ps
`default_nettype none

module srb_datapath
   import srb_pkg::*;
#(
   parameter int WINDOW_SLOTS = DEFAULT_WINDOW_SLOTS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_item,
   input  wire ctrl_cmd_type  cmd,
   output      dp_status_type status,
   output      logic          rsp_strobe,
   output      rsp_type       rsp_item
);

   localparam int IDX_BITS = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_BITS = $clog2(WINDOW_SLOTS + 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(WINDOW_SLOTS - 1);
   localparam logic [IDX_BITS:0]   SLOTS_EXT = (IDX_BITS + 1)'(WINDOW_SLOTS);
   localparam logic [SEQ_BITS-1:0] SLOTS_SEQ = SEQ_BITS'(WINDOW_SLOTS);
   localparam logic [SEQ_BITS-1:0] SEQ_ONE   = SEQ_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

   req_type                  req_ff;
   logic [SEQ_BITS-1:0]      expected_ff, expected_in;
   logic [IDX_BITS-1:0]      head_ff, head_in;
   logic [IDX_BITS-1:0]      scan_ff, scan_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [WINDOW_SLOTS-1:0]  valid_ff, valid_in;
   logic                     strobe_ff, strobe_in;
   rsp_type                  rsp_ff, rsp_in;
   slot_entry_type           rd_data_ff;
   slot_entry_type           slot_mem [WINDOW_SLOTS];

   logic [SEQ_BITS-1:0]      diff;
   logic [IDX_BITS:0]        slot_sum;
   logic [IDX_BITS-1:0]      slot_idx;
   logic [IDX_BITS-1:0]      head_next;
   logic [IDX_BITS-1:0]      scan_next;
   logic [IDX_BITS-1:0]      rd_addr;
   slot_entry_type           wr_entry;

   // distance from the expected number, then its ring slot past head
   assign diff     = req_ff.seq_number - expected_ff;
   assign slot_sum = {1'b0, head_ff} + {1'b0, diff[IDX_BITS-1:0]};
   assign slot_idx = (slot_sum >= SLOTS_EXT) ? IDX_BITS'(slot_sum - SLOTS_EXT)
                                             : slot_sum[IDX_BITS-1:0];
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_BITS'(1);
   assign scan_next = (scan_ff == LAST_IDX) ? '0 : scan_ff + IDX_BITS'(1);
   assign rd_addr   = cmd.read_from_scan ? scan_ff : head_ff;

   assign wr_entry.seq_number = req_ff.seq_number;
   assign wr_entry.payload    = req_ff.payload;
   assign wr_entry.has_task   = req_ff.has_task;

   assign status.is_flush        = (req_ff.operation == OP_FLUSH);
   assign status.is_stale        = (req_ff.seq_number < expected_ff);
   assign status.is_too_far      = (diff >= SLOTS_SEQ);
   assign status.diff_zero       = (diff == '0);
   assign status.count_zero      = (count_ff == '0);
   assign status.count_one       = (count_ff == CNT_ONE);
   assign status.head_next_valid = valid_ff[head_next];
   assign status.scan_valid      = valid_ff[scan_ff];

   always_comb begin
      expected_in = expected_ff;
      head_in     = head_ff;
      scan_in     = scan_ff;
      count_in    = count_ff;
      valid_in    = valid_ff;
      if (cmd.write_slot) begin
         valid_in[slot_idx] = 1'b1;
         if (!valid_ff[slot_idx]) begin
            count_in = count_ff + CNT_ONE;
         end
      end
      if (cmd.release_head) begin
         valid_in[head_ff] = 1'b0;
         count_in          = count_ff - CNT_ONE;
         head_in           = head_next;
         expected_in       = expected_ff + SEQ_ONE;
      end
      if (cmd.release_scan) begin
         valid_in[scan_ff] = 1'b0;
         count_in          = count_ff - CNT_ONE;
      end
      if (cmd.scan_init) begin
         scan_in = head_ff;
      end else if (cmd.scan_step || cmd.release_scan) begin
         scan_in = scan_next;
      end
      if (cmd.flush_done) begin
         head_in     = '0;
         expected_in = SEQ_ONE;
      end
   end

   always_comb begin
      strobe_in = cmd.emit;
      rsp_in    = rsp_ff;
      if (cmd.emit) begin
         rsp_in.status = cmd.emit_status;
         rsp_in.last   = cmd.emit_last;
         case (cmd.emit_src)
            SRC_REQUEST: begin
               rsp_in.out_seq_number = req_ff.seq_number;
               rsp_in.out_payload    = req_ff.payload;
               rsp_in.out_has_task   = req_ff.has_task;
            end
            SRC_SLOT: begin
               rsp_in.out_seq_number = rd_data_ff.seq_number;
               rsp_in.out_payload    = rd_data_ff.payload;
               rsp_in.out_has_task   = rd_data_ff.has_task;
            end
            default: begin
               rsp_in.out_seq_number = '0;
               rsp_in.out_payload    = '0;
               rsp_in.out_has_task   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= SEQ_ONE;
         head_ff     <= '0;
         scan_ff     <= '0;
         count_ff    <= '0;
         valid_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         head_ff     <= head_in;
         scan_ff     <= scan_in;
         count_ff    <= count_in;
         valid_ff    <= valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   // slot store, registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         slot_mem[slot_idx] <= wr_entry;
      end
      if (cmd.read_slot) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == count_ff)
      else $error("occupancy count differs from valid bits");

   a_release_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.release_head || cmd.release_scan) |->
         (valid_ff[head_ff] || !cmd.release_head) && (valid_ff[scan_ff] || !cmd.release_scan))
      else $error("release of an empty slot");

   a_release_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.release_head && !cmd.flush_done) |=>
         (expected_ff == $past(expected_ff) + SEQ_ONE) && (head_ff != $past(head_ff)))
      else $error("in-order release did not advance head and expected number");

   a_flush_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_done |=> (head_ff == '0) && (expected_ff == SEQ_ONE) && (valid_ff == '0))
      else $error("flush left slots or pointers behind");

endmodule

`default_nettype wire

@@ rtl/core/srb_controller.sv @@
// controller of the sequence reorder buffer: one-hot state machine that
// sequences decode, slot writes, in-order release and flush scan; uses srb_pkg
`timescale 1ns / 1ps
`default_nettype none

module srb_controller
   import srb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   output      logic          busy,
   output      ctrl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_RREAD  = 6'b000100,
      S_REMIT  = 6'b001000,
      S_FSCAN  = 6'b010000,
      S_FEMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.is_flush) begin
               if (status.count_zero) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_src    = SRC_ZERO;
                  cmd.emit_status = ST_FLUSH_EMPTY;
                  cmd.emit_last   = 1'b1;
                  cmd.flush_done  = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_FSCAN;
               end
            end else if (status.is_stale) begin
               cmd.emit        = 1'b1;
               cmd.emit_src    = SRC_REQUEST;
               cmd.emit_status = ST_STALE;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end else if (status.is_too_far) begin
               cmd.emit        = 1'b1;
               cmd.emit_src    = SRC_REQUEST;
               cmd.emit_status = ST_TOO_FAR;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.write_slot = 1'b1;
               if (status.diff_zero) begin
                  state_in = S_RREAD;
               end else begin
                  cmd.emit        = 1'b1;
                  cmd.emit_src    = SRC_REQUEST;
                  cmd.emit_status = ST_HELD;
                  cmd.emit_last   = 1'b1;
                  state_in        = S_IDLE;
               end
            end
         end
         S_RREAD: begin
            cmd.read_slot = 1'b1;
            state_in      = S_REMIT;
         end
         S_REMIT: begin
            // burst ends where the next slot past head is empty
            cmd.emit         = 1'b1;
            cmd.emit_src     = SRC_SLOT;
            cmd.emit_status  = ST_RELEASED;
            cmd.emit_last    = !status.head_next_valid;
            cmd.release_head = 1'b1;
            state_in         = status.head_next_valid ? S_RREAD : S_IDLE;
         end
         S_FSCAN: begin
            if (status.scan_valid) begin
               cmd.read_slot      = 1'b1;
               cmd.read_from_scan = 1'b1;
               state_in           = S_FEMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FEMIT: begin
            cmd.emit         = 1'b1;
            cmd.emit_src     = SRC_SLOT;
            cmd.emit_status  = ST_FLUSHED;
            cmd.emit_last    = status.count_one;
            cmd.release_scan = 1'b1;
            if (status.count_one) begin
               cmd.flush_done = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_FSCAN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (state_ff == S_IDLE) && start)
      else $error("request loaded outside idle");

   a_emit_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> (state_ff == S_IDLE))
      else $error("final result not followed by idle");

   a_flush_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FSCAN) |-> !status.count_zero)
      else $error("flush scan with nothing held");

endmodule

`default_nettype wire

@@ rtl/core/sequence_reorder_buffer.sv @@
// top level of the sequence reorder buffer
// instantiates srb_controller and srb_datapath, uses srb_pkg
`timescale 1ns / 1ps
`default_nettype none

// Restores sequence order of tagged requests. A request is taken on a rising
// edge with start high and busy low; req_item.operation selects deliver or
// flush. Results come out on rsp_item, each valid for exactly one cycle with
// rsp_strobe high; rsp_item.last marks the final result of a request. The
// receiver cannot stall: every strobed result is taken.
// Steps per request, from accept to busy low again:
//   held, stale or too-far deliver: decide, then one result strobed through
//     the result register
//   in-order deliver releasing n items: decide, then for each released item
//     a slot memory read, then the result register
//   flush holding n items: decide, then a scan from head over each slot up to
//     the last held one, emitting each held item as it is found; empty flush:
//     one result from decide
// Each released item passes in turn through the registered slot memory read
// and the result register; no new request is taken until busy is low.
// Reset (synchronous, active high) empties all slots, sets the expected
// number to 1 and the head to slot 0; no clearing pass is needed, the block
// takes a request as soon as reset is released.
module sequence_reorder_buffer
   import srb_pkg::*;
#(
   parameter int WINDOW_SLOTS = DEFAULT_WINDOW_SLOTS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_strobe,
   output      rsp_type rsp_item
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   srb_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   srb_datapath #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

@@ tb/sv/sequence_reorder_buffer_test.sv @@
// self-checking testbench for the sequence reorder buffer
// drives requests with random gaps and checks every strobed result against a local predictor
// depends on srb_pkg and sequence_reorder_buffer
`timescale 1ns / 1ps

module sequence_reorder_buffer_test;
   import srb_pkg::*;

   localparam int SLOTS     = DEFAULT_WINDOW_SLOTS;
   localparam int IDX_BITS  = $clog2(SLOTS);
   localparam int RANDOM_ITEMS = 246;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // predictor copy of the window
   logic                  held_valid [SLOTS];
   slot_entry_type        held_entry [SLOTS];
   logic [IDX_BITS-1:0]   head_slot;
   logic [SEQ_BITS-1:0]   next_expected;

   rsp_type pending_results[$];
   int      error_count;
   bit      idle_on;

   sequence_reorder_buffer #(
      .WINDOW_SLOTS(SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, want, got);
      error_count++;
   endtask

   function automatic void push_result(logic [2:0] st, slot_entry_type e, logic is_last);
      rsp_type r;
      r.status         = st;
      r.out_seq_number = e.seq_number;
      r.out_payload    = e.payload;
      r.out_has_task   = e.has_task;
      r.last           = is_last;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_reorder(req_type rq);
      slot_entry_type      incoming;
      logic [SEQ_BITS-1:0] diff;
      logic [IDX_BITS-1:0] idx;
      int                  count;
      incoming.seq_number = rq.seq_number;
      incoming.payload    = rq.payload;
      incoming.has_task   = rq.has_task;
      if (rq.operation == OP_FLUSH) begin
         count = 0;
         for (int k = 0; k < SLOTS; k++) begin
            if (held_valid[k]) count++;
         end
         if (count == 0) push_result(ST_FLUSH_EMPTY, '0, 1'b1);
         // ascending order starts at the head, gaps are skipped
         idx = head_slot;
         for (int k = 0; k < SLOTS; k++) begin
            if (held_valid[idx]) begin
               count--;
               push_result(ST_FLUSHED, held_entry[idx], count == 0);
               held_valid[idx] = 1'b0;
            end
            idx++;
         end
         head_slot     = '0;
         next_expected = SEQ_BITS'(1);
      end else if (rq.seq_number < next_expected) begin
         push_result(ST_STALE, incoming, 1'b1);
      end else begin
         diff = rq.seq_number - next_expected;
         if (diff >= SLOTS) begin
            push_result(ST_TOO_FAR, incoming, 1'b1);
         end else begin
            idx             = head_slot + diff[IDX_BITS-1:0];
            held_valid[idx] = 1'b1;
            held_entry[idx] = incoming;
            if (diff != 0) begin
               push_result(ST_HELD, incoming, 1'b1);
            end else begin
               count = 0;
               idx   = head_slot;
               while (count < SLOTS && held_valid[idx]) begin
                  count++;
                  idx++;
               end
               for (int k = 0; k < count; k++) begin
                  push_result(ST_RELEASED, held_entry[head_slot], k == count - 1);
                  held_valid[head_slot] = 1'b0;
                  next_expected++;
                  head_slot++;
               end
            end
         end
      end
   endfunction

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing expected", 64'd0, 64'(got.out_seq_number));
      end else begin
         want = pending_results[0];
         pending_results.delete(0);
         if (got.status != want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
         if (got.out_seq_number != want.out_seq_number)
            report_mismatch("out_seq_number", 64'(want.out_seq_number),
                            64'(got.out_seq_number));
         if (got.out_payload != want.out_payload)
            report_mismatch("out_payload", 64'(want.out_payload), 64'(got.out_payload));
         if (got.out_has_task != want.out_has_task)
            report_mismatch("out_has_task", 64'(want.out_has_task), 64'(got.out_has_task));
         if (got.last != want.last)
            report_mismatch("last", 64'(want.last), 64'(got.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) check_result(rsp_item);
   end

   function automatic logic [PAYLOAD_BITS-1:0] random_payload();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void shuffle_seqs(ref logic [SEQ_BITS-1:0] q[$]);
      logic [SEQ_BITS-1:0] tmp;
      int                  k;
      for (int j = q.size() - 1; j > 0; j--) begin
         k    = $urandom_range(j, 0);
         tmp  = q[j];
         q[j] = q[k];
         q[k] = tmp;
      end
   endfunction

   // called just after a falling edge; leaves start high for the next request unless it inserts a random idle gap
   task automatic send_request(logic op, logic [SEQ_BITS-1:0] seq,
                               logic [PAYLOAD_BITS-1:0] pay, logic work);
      req_item.operation  = op;
      req_item.seq_number = seq;
      req_item.payload    = pay;
      req_item.has_task   = work;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predict_reorder(req_item);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 36) begin
         start = 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_empty_flush();
      send_request(OP_FLUSH, '0, '0, 1'b0);
   endtask

   task automatic test_rejects();
      send_request(OP_DELIVER, 32'd0, '1, 1'b1);
      // farthest number that still fits in the window
      send_request(OP_DELIVER, 32'd64, random_payload(), 1'b0);
      send_request(OP_DELIVER, 32'd65, random_payload(), 1'b1);
      send_request(OP_DELIVER, 32'hFFFF_FFFF, '1, 1'b1);
      send_request(OP_FLUSH, '1, '1, 1'b1);
   endtask

   task automatic test_in_order_and_held();
      send_request(OP_DELIVER, 32'd1, '1, 1'b1);
      send_request(OP_DELIVER, 32'd3, '0, 1'b0);
      send_request(OP_DELIVER, 32'd2, random_payload(), 1'b1);
      send_request(OP_DELIVER, 32'd1, random_payload(), 1'b0);
   endtask

   task automatic test_duplicate_and_flush();
      send_request(OP_DELIVER, 32'd6, random_payload(), 1'b1);
      send_request(OP_DELIVER, 32'd6, random_payload(), 1'b0);
      send_request(OP_DELIVER, 32'd9, random_payload(), 1'b1);
      send_request(OP_FLUSH, 32'd0, '0, 1'b0);
      wait_drained();
   endtask

   // every slot filled, then the head item releases the whole window at once
   task automatic test_full_window();
      logic [SEQ_BITS-1:0] order[$];
      send_request(OP_FLUSH, '0, '0, 1'b0);
      for (int s = 2; s <= SLOTS; s++) order.insert(order.size(), SEQ_BITS'(s));
      shuffle_seqs(order);
      order.insert(order.size(), SEQ_BITS'(1));
      foreach (order[j])
         send_request(OP_DELIVER, order[j], random_payload(), 1'($urandom_range(1)));
   endtask

   task automatic test_random_traffic();
      logic [SEQ_BITS-1:0] backlog[$];
      logic [SEQ_BITS-1:0] next_issue;
      logic [SEQ_BITS-1:0] last_seq;
      logic [SEQ_BITS-1:0] s;
      int                  issued;
      int                  roll;
      int                  n;
      next_issue = next_expected;
      last_seq   = next_expected;
      issued     = 0;
      while (issued < RANDOM_ITEMS) begin
         // quiet stretch with back-to-back requests
         idle_on = !(issued >= 80 && issued < 150);
         if (issued == 160) wait_drained();
         roll = $urandom_range(99);
         if (roll < 5) begin
            send_request(OP_FLUSH, $urandom(), random_payload(), 1'($urandom_range(1)));
            backlog.delete();
            next_issue = SEQ_BITS'(1);
         end else begin
            if (roll < 11) begin
               s = $urandom_range(next_expected - 1, 0);
            end else if (roll < 14) begin
               s = next_expected + SEQ_BITS'(SLOTS) + SEQ_BITS'($urandom_range(200));
            end else if (roll < 16) begin
               s = $urandom();
            end else if (roll < 19) begin
               s = last_seq;
            end else begin
               if (backlog.size() == 0) begin
                  n = $urandom_range(16, 1);
                  // occasionally drop a number so the window holds a gap
                  for (int j = 0; j < n; j++) begin
                     if ($urandom_range(99) >= 8)
                        backlog.insert(backlog.size(), next_issue + SEQ_BITS'(j));
                  end
                  next_issue += SEQ_BITS'(n);
                  shuffle_seqs(backlog);
               end
               if (backlog.size() != 0) begin
                  s = backlog[0];
                  backlog.delete(0);
               end else begin
                  s = next_expected;
               end
            end
            last_seq = s;
            send_request(OP_DELIVER, s, random_payload(), 1'($urandom_range(1)));
         end
         issued++;
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      error_count = 0;
      idle_on     = 1'b1;
      head_slot   = '0;
      next_expected = SEQ_BITS'(1);
      for (int k = 0; k < SLOTS; k++) begin
         held_valid[k] = 1'b0;
         held_entry[k] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_flush();
      test_rejects();
      test_in_order_and_held();
      test_duplicate_and_flush();
      test_full_window();
      test_random_traffic();

      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
